FILE: rtl/b64lw_pkg.sv
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared constants and the base64 symbol lookup for the line-wrapped encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

	localparam int LINE_CHARS      = 64;
	localparam int GROUPS_PER_LINE = LINE_CHARS / 4;
	localparam int GRP_W           = $clog2(GROUPS_PER_LINE + 1);

	localparam int BATCH_LEN = 5;          // most characters one item can cause
	localparam int CNT_W     = 3;

	localparam logic [7:0] CH_PAD = 8'd61; // '='
	localparam logic [7:0] CH_LF  = 8'd10; // line feed

	// Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
	function automatic logic [7:0] b64_sym(input logic [5:0] idx);
		logic [7:0] wide;
		wide = {2'b00, idx};
		if (idx < 6'd26)
			return 8'd65 + wide;
		else if (idx < 6'd52)
			return 8'd71 + wide;            // 'a' - 26
		else if (idx < 6'd62)
			return wide - 8'd4;             // '0' - 52
		else if (idx == 6'd62)
			return 8'd43;                   // '+'
		else
			return 8'd47;                   // '/'
	endfunction

endpackage

FILE: rtl/base64_line_wrapped_encoder.sv
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// The characters of an accepted item pass through the batch register, then
// the output register, before they reach m_tdata.
// Throughput: one character per cycle while m_tready is high; an item
// causes 0, 4 or 5 characters; the single output register drains the batch.
// Reset (arst_n low): no bytes held, line count zero, both stages empty.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder (
	input  logic       clk,
	input  logic       arst_n,

	// input items
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // final_byte

	// result items
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tlast,   // run_last
	output logic       m_tuser    // [0] message_end
);
	import b64lw_pkg::*;

	// encoder state
	logic [15:0]      pend_q;     // held bytes, newest in the low byte
	logic [1:0]       phase_q;    // number of held bytes
	logic [GRP_W-1:0] groups_q;   // full groups on the current line

	// batch register: characters still to be sent for the last item
	logic [7:0]       chars_q [BATCH_LEN];
	logic [CNT_W-1:0] cnt_q;
	logic             mend_q;     // batch closes the message

	// output register
	logic             o_valid_q;
	logic [7:0]       o_char_q;
	logic             o_last_q;
	logic             o_end_q;

	logic             out_load;   // output register can take a character
	logic             pop;        // a character moves batch -> output
	logic             accept;

	// next batch and next state, computed from the incoming item
	logic [7:0]       nb_chars [BATCH_LEN];
	logic [CNT_W-1:0] nb_cnt;
	logic             nb_mend;
	logic [15:0]      n_pend;
	logic [1:0]       n_phase;
	logic [GRP_W-1:0] n_groups;
	logic [23:0]      grp3;
	logic [17:0]      grp2;
	logic [11:0]      grp1;
	logic             line_full;

	assign out_load = !o_valid_q || m_tready;
	assign pop      = (cnt_q != '0) && out_load;
	// take a new item once the batch is empty or its last character leaves now
	assign s_tready = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_load);
	assign accept   = s_tvalid && s_tready;

	assign grp3      = {pend_q, s_tdata};
	assign grp2      = {pend_q[7:0], s_tdata, 2'b00};
	assign grp1      = {s_tdata, 4'b0000};
	assign line_full = (groups_q == GRP_W'(GROUPS_PER_LINE - 1));

	always_comb begin
		for (int i = 0; i < BATCH_LEN; i++)
			nb_chars[i] = CH_LF;
		nb_cnt   = '0;
		nb_mend  = 1'b0;
		n_pend   = pend_q;
		n_phase  = phase_q;
		n_groups = groups_q;

		if (phase_q == 2'd2) begin
			// third byte of a group: four symbols, maybe a wrap
			nb_chars[0] = b64_sym(grp3[23:18]);
			nb_chars[1] = b64_sym(grp3[17:12]);
			nb_chars[2] = b64_sym(grp3[11:6]);
			nb_chars[3] = b64_sym(grp3[5:0]);
			n_pend      = '0;
			n_phase     = 2'd0;
			if (s_tlast) begin
				nb_cnt  = CNT_W'(5);
				nb_mend = 1'b1;
			end else if (line_full) begin
				nb_cnt   = CNT_W'(5);
				n_groups = '0;
			end else begin
				nb_cnt   = CNT_W'(4);
				n_groups = groups_q + GRP_W'(1);
			end
		end else if (!s_tlast) begin
			// hold the byte, nothing to send yet
			n_pend  = {pend_q[7:0], s_tdata};
			n_phase = (phase_q == 2'd1) ? 2'd2 : 2'd1;
		end else if (phase_q == 2'd1) begin
			// two bytes at message end: three symbols and one pad
			nb_chars[0] = b64_sym(grp2[17:12]);
			nb_chars[1] = b64_sym(grp2[11:6]);
			nb_chars[2] = b64_sym(grp2[5:0]);
			nb_chars[3] = CH_PAD;
			nb_cnt      = CNT_W'(5);
			nb_mend     = 1'b1;
		end else begin
			// one byte at message end: two symbols and two pads
			nb_chars[0] = b64_sym(grp1[11:6]);
			nb_chars[1] = b64_sym(grp1[5:0]);
			nb_chars[2] = CH_PAD;
			nb_chars[3] = CH_PAD;
			nb_cnt      = CNT_W'(5);
			nb_mend     = 1'b1;
		end

		if (s_tlast) begin
			n_pend   = '0;
			n_phase  = 2'd0;
			n_groups = '0;
		end
	end

	// encoder state and batch control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			phase_q  <= 2'd0;
			groups_q <= '0;
			cnt_q    <= '0;
			mend_q   <= 1'b0;
		end else begin
			if (accept) begin
				pend_q   <= n_pend;
				phase_q  <= n_phase;
				groups_q <= n_groups;
				cnt_q    <= nb_cnt;
				mend_q   <= nb_mend;
			end else if (pop) begin
				cnt_q    <= cnt_q - CNT_W'(1);
			end
		end
	end

	// batch characters: load on accept, shift down on each pop
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < BATCH_LEN; i++)
				chars_q[i] <= nb_chars[i];
		end else if (pop) begin
			for (int i = 0; i < BATCH_LEN - 1; i++)
				chars_q[i] <= chars_q[i+1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (out_load) begin
			o_valid_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			o_char_q <= chars_q[0];
			o_last_q <= (cnt_q == CNT_W'(1));
			o_end_q  <= (cnt_q == CNT_W'(1)) && mend_q;
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = o_char_q;
	assign m_tlast  = o_last_q;
	assign m_tuser  = o_end_q;

endmodule

FILE: verif/base64_line_wrapped_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_tb
// Self-checking bench for the line-wrapped base64 encoder. Short hand-picked
// messages come first, then random messages. Two of these are long enough to
// fill a line: one ends exactly on a full line, one wraps and carries on.
// A behavioral encoder predicts every character, and a monitor checks each
// output item in order. Both sides idle in random bursts, the sink holds off
// once for a long stretch, and the source sometimes waits for the output to
// drain before it starts a message.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder_tb;

	import b64lw_pkg::*;

	localparam int LINE_GROUPS  = LINE_CHARS / 4;
	localparam int RANDOM_BYTES = 115;
	localparam int QUIET_TAIL   = 25;     // last items are sent with no idling
	localparam int LONG_HOLD    = 80;     // cycles of the one long sink stall
	localparam int HOLD_AT      = 50;     // characters checked before that stall
	localparam int TAIL_CYCLES  = 20;     // settle time once nothing is expected
	localparam int STALL_LIMIT  = 2000;   // cycles with no handshake on either side
	localparam int SHOW_ERRORS  = 10;

	localparam logic [8*64-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// one input byte as the source sends it
	typedef struct {
		logic [7:0] data;
		logic       fin;
		bit         drain_first;   // wait for all output before sending
	} msg_byte_t;

	// one output character as the encoder should produce it
	typedef struct packed {
		logic [7:0] ch;
		logic       run_last;
		logic       msg_end;
	} enc_char_t;

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'd0;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	msg_byte_t  byte_q[$];      // bytes not yet offered
	enc_char_t  char_q[$];      // characters still to come out
	msg_byte_t  cur_byte;

	// encoder state of the predictor
	logic [15:0] held_bytes   = 16'd0;
	int          held_count   = 0;
	int          line_groups  = 0;

	int  errors         = 0;
	int  bytes_sent     = 0;
	int  messages_sent  = 0;
	int  chars_checked  = 0;
	int  line_wraps     = 0;
	int  full_line_ends = 0;
	int  src_gap        = 0;
	int  sink_gap       = 0;
	int  long_hold_left = 0;
	bit  long_hold_done = 0;
	bit  quiet_tail     = 0;
	int  idle_cycles    = 0;

	base64_line_wrapped_encoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] data_byte
		.s_tlast  (s_tlast),   // final_byte
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [7:0] out_char
		.m_tlast  (m_tlast),   // run_last
		.m_tuser  (m_tuser)    // [0] message_end
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] symbol_of(input logic [5:0] idx);
		return ALPHABET[8*(63 - idx) +: 8];
	endfunction

	// Run one accepted byte through the behavioral encoder and queue
	// the characters it causes.
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [23:0] grp;
		enc_char_t   burst[$];
		if (held_count == 2) begin
			grp = {held_bytes, b};
			burst.push_back('{symbol_of(grp[23:18]), 1'b0, 1'b0});
			burst.push_back('{symbol_of(grp[17:12]), 1'b0, 1'b0});
			burst.push_back('{symbol_of(grp[11:6]), 1'b0, 1'b0});
			burst.push_back('{symbol_of(grp[5:0]), 1'b0, 1'b0});
			held_bytes  = 16'd0;
			held_count  = 0;
			line_groups = line_groups + 1;
			if (line_groups >= LINE_GROUPS) begin
				// a line that fills on the final byte gets only the closing LF
				if (fin) begin
					full_line_ends++;
				end else begin
					line_groups = 0;
					line_wraps++;
					burst.push_back('{CH_LF, 1'b0, 1'b0});
				end
			end
		end else if (!fin) begin
			// byte is only held, nothing comes out
			held_bytes = {held_bytes[7:0], b};
			held_count = held_count + 1;
		end else if (held_count == 0) begin
			grp = {b, 16'd0};
			burst.push_back('{symbol_of(grp[23:18]), 1'b0, 1'b0});
			burst.push_back('{symbol_of(grp[17:12]), 1'b0, 1'b0});
			burst.push_back('{CH_PAD, 1'b0, 1'b0});
			burst.push_back('{CH_PAD, 1'b0, 1'b0});
		end else begin
			grp = {held_bytes[7:0], b, 8'd0};
			burst.push_back('{symbol_of(grp[23:18]), 1'b0, 1'b0});
			burst.push_back('{symbol_of(grp[17:12]), 1'b0, 1'b0});
			burst.push_back('{symbol_of(grp[11:6]), 1'b0, 1'b0});
			burst.push_back('{CH_PAD, 1'b0, 1'b0});
		end
		if (fin) begin
			burst.push_back('{CH_LF, 1'b0, 1'b1});
			held_bytes  = 16'd0;
			held_count  = 0;
			line_groups = 0;
		end
		if (burst.size() != 0)
			burst[burst.size() - 1].run_last = 1'b1;
		foreach (burst[i])
			char_q.push_back(burst[i]);
	endtask

	task automatic add_byte(input logic [7:0] data, input logic fin, input bit drain_first);
		msg_byte_t item;
		item.data        = data;
		item.fin         = fin;
		item.drain_first = drain_first;
		byte_q.push_back(item);
	endtask

	// Random message of len bytes; the last one carries the final flag.
	task automatic add_message(input int len, input bit drain_first);
		for (int i = 0; i < len; i++)
			add_byte(8'($urandom_range(0, 255)), i == len - 1, drain_first && i == 0);
	endtask

	// ------------------------------------------------------------------
	// Source: offers queued bytes, predicts each one at acceptance.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'd0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				encode_byte(cur_byte.data, cur_byte.fin);
				bytes_sent++;
				if (cur_byte.fin)
					messages_sent++;
				if (!quiet_tail && $urandom_range(0, 4) == 0)
					src_gap = $urandom_range(1, 9);
			end
			quiet_tail <= byte_q.size() < QUIET_TAIL;
			// slot is free when nothing is offered or the offer just went in
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (byte_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (byte_q[0].drain_first && char_q.size() != 0) begin
					// hold the next message until the encoder has emptied
					s_tvalid <= 1'b0;
				end else begin
					cur_byte = byte_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur_byte.data;
					s_tlast  <= cur_byte.fin;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sink: checks each output item against the oldest prediction and
	// throttles m_tready.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (char_q.size() == 0) begin
					errors++;
					if (errors <= SHOW_ERRORS)
						$display("%t unexpected char: data=%02h last=%b end=%b",
							$realtime, m_tdata, m_tlast, m_tuser);
				end else begin
					if (m_tdata !== char_q[0].ch || m_tlast !== char_q[0].run_last ||
							m_tuser !== char_q[0].msg_end) begin
						errors++;
						if (errors <= SHOW_ERRORS)
							$display("%t char %0d: expected data=%02h last=%b end=%b, got data=%02h last=%b end=%b",
								$realtime, chars_checked, char_q[0].ch, char_q[0].run_last,
								char_q[0].msg_end, m_tdata, m_tlast, m_tuser);
					end
					void'(char_q.pop_front());
					chars_checked++;
				end
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				m_tready <= 1'b0;
			end else if (!long_hold_done && chars_checked >= HOLD_AT) begin
				// source keeps offering meanwhile, so the encoder backs up
				long_hold_done = 1'b1;
				long_hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				sink_gap = $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: a hang shows as a long run of cycles with no handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%t no handshake for %0d cycles, %0d chars outstanding",
					$realtime, idle_cycles, char_q.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int msg_idx;
		int rand_total;
		int len;

		// directed: single-byte and two-byte flushes, the bit extremes,
		// a whole group on the final byte, '+' and '/' symbols
		add_byte(8'h00, 1'b1, 0);
		add_byte(8'hFF, 1'b1, 0);
		add_byte(8'hFF, 1'b0, 0);
		add_byte(8'h00, 1'b1, 0);
		add_byte(8'h00, 1'b0, 0);
		add_byte(8'hFF, 1'b0, 0);
		add_byte(8'h80, 1'b1, 0);
		add_byte(8'hFB, 1'b0, 0);
		add_byte(8'hEF, 1'b0, 0);
		add_byte(8'hBE, 1'b0, 0);
		add_byte(8'hFF, 1'b0, 0);
		add_byte(8'hFF, 1'b0, 0);
		add_byte(8'hFF, 1'b0, 0);
		add_byte(8'h01, 1'b0, 0);
		add_byte(8'h02, 1'b1, 0);

		// random messages; one fills a line exactly at its end,
		// one wraps to a second line
		msg_idx    = 0;
		rand_total = 0;
		while (rand_total < RANDOM_BYTES) begin
			if (msg_idx == 1)
				len = 3 * LINE_GROUPS;
			else if (msg_idx == 3)
				len = 3 * LINE_GROUPS + 4;
			else
				len = $urandom_range(1, 12);
			add_message(len, msg_idx == 0 || $urandom_range(0, 5) == 0);
			rand_total += len;
			msg_idx++;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() != 0 || s_tvalid || char_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (char_q.size() != 0) begin
			errors++;
			$display("%0d predicted chars never came out", char_q.size());
		end
		$display("Sent %0d bytes in %0d messages; checked %0d chars.",
			bytes_sent, messages_sent, chars_checked);
		$display("Lines wrapped mid-message: %0d; messages ending on a full line: %0d.",
			line_wraps, full_line_ends);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
